// ===== sv/arm_instruction_field_decoder_macros.svh =====
// Assertion macros for the ARM instruction field decoder.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ARM_INSTRUCTION_FIELD_DECODER_MACROS_SVH
`define ARM_INSTRUCTION_FIELD_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define AIFD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aifd assertion failed");
// Next-cycle implication.
`define AIFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aifd assertion failed");
`else
`define AIFD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define AIFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/aifd_pkg.sv =====
// Shared types and constants for the ARM instruction field decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package aifd_pkg;

   typedef struct packed {
      logic [31:0] fetch_address;
      logic [31:0] instr_word;
   } req_type;

   typedef struct packed {
      logic [2:0]  instr_class;
      logic [3:0]  condition;
      logic [3:0]  alu_op;
      logic        suffix_flag;
      logic [1:0]  variant;
      logic [3:0]  reg_d;
      logic [3:0]  reg_n;
      logic [3:0]  reg_m;
      logic [3:0]  reg_s;
      logic [1:0]  operand_form;
      logic [1:0]  shift_kind;
      logic [31:0] value;
   } rsp_type;

   // Result classes
   localparam logic [2:0] CLASS_BRANCH  = 3'd0;
   localparam logic [2:0] CLASS_MUL     = 3'd1;
   localparam logic [2:0] CLASS_SWI     = 3'd2;
   localparam logic [2:0] CLASS_DP      = 3'd3;
   localparam logic [2:0] CLASS_XFER    = 3'd4;
   localparam logic [2:0] CLASS_BLOCK   = 3'd5;
   localparam logic [2:0] CLASS_UNKNOWN = 3'd6;

   // Operand forms
   localparam logic [1:0] FORM_REG       = 2'd0;
   localparam logic [1:0] FORM_SHIFT_IMM = 2'd1;
   localparam logic [1:0] FORM_SHIFT_REG = 2'd2;
   localparam logic [1:0] FORM_IMM       = 2'd3;

   // Codes of instruction bits 27..25
   localparam logic [2:0] TOP_DP_REG   = 3'd0;
   localparam logic [2:0] TOP_DP_IMM   = 3'd1;
   localparam logic [2:0] TOP_XFER_IMM = 3'd2;
   localparam logic [2:0] TOP_XFER_REG = 3'd3;
   localparam logic [2:0] TOP_BLOCK    = 3'd4;
   localparam logic [2:0] TOP_BRANCH   = 3'd5;

   localparam logic [31:0] MUL_MASK    = 32'h0fc0_00f0;
   localparam logic [31:0] MUL_MATCH   = 32'h0000_0090;
   localparam logic [31:0] SWI_MASK    = 32'h0f00_0000;
   localparam logic [31:0] SHIFT_MASK  = 32'h0000_0ff0;
   localparam logic [31:0] PC_AHEAD    = 32'd8;

endpackage

`default_nettype wire

// ===== sv/aifd_in_reg.sv =====
// Input register stage of the ARM instruction field decoder.
// Depends on aifd_pkg for the request payload type.
`default_nettype none

module aifd_in_reg
   import aifd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         stage_valid,
   input  wire logic    stage_ready,
   output req_type      stage_payload
);

   logic    valid_ff, valid_in;
   req_type data_ff;

   // Take a new beat when empty or when the held one moves on this cycle.
   assign req_ready = !valid_ff || stage_ready;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_payload;
      end
   end

   assign stage_valid   = valid_ff;
   assign stage_payload = data_ff;

endmodule

`default_nettype wire

// ===== sv/aifd_decode.sv =====
// Combinational field decode of one ARM instruction word.
// Depends on aifd_pkg for payload types, class and form codes.
`default_nettype none

module aifd_decode
   import aifd_pkg::*;
(
   input  wire req_type in_item,
   output rsp_type      out_item
);

   // Register operand with optional shift, bits 11..0.
   function automatic rsp_type reg_operand(input logic [31:0] w, input rsp_type r);
      rsp_type t;
      t = r;
      t.reg_m = w[3:0];
      if ((w & SHIFT_MASK) == 32'd0) begin
         t.operand_form = FORM_REG;
      end else if (w[4]) begin
         t.operand_form = FORM_SHIFT_REG;
         t.shift_kind   = w[6:5];
         t.reg_s        = w[11:8];
      end else begin
         t.operand_form = FORM_SHIFT_IMM;
         t.shift_kind   = w[6:5];
         t.value        = {27'd0, w[11:7]};
      end
      return t;
   endfunction

   logic [31:0] w;
   logic [2:0]  top3;
   logic [31:0] branch_off;
   logic [4:0]  rot;
   logic [63:0] imm_pair;
   logic [63:0] imm_rot;

   assign w    = in_item.instr_word;
   assign top3 = w[27:25];

   // Word offset, sign-extended and scaled to bytes
   assign branch_off = {{6{w[23]}}, w[23:0], 2'b00};

   // Rotate right by twice the rotate field: shift a doubled copy
   assign rot      = {w[11:8], 1'b0};
   assign imm_pair = {24'd0, w[7:0], 24'd0, w[7:0]};
   assign imm_rot  = imm_pair >> rot;

   always_comb begin
      out_item           = '0;
      out_item.condition = w[31:28];
      if (top3 == TOP_BRANCH) begin
         out_item.instr_class = CLASS_BRANCH;
         out_item.variant     = {1'b0, w[24]};
         out_item.value       = in_item.fetch_address + PC_AHEAD + branch_off;
      end else if ((w & MUL_MASK) == MUL_MATCH) begin
         out_item.instr_class = CLASS_MUL;
         out_item.suffix_flag = w[20];
         out_item.variant     = {1'b0, w[21]};
         out_item.reg_d       = w[19:16];
         out_item.reg_n       = w[15:12];
         out_item.reg_s       = w[11:8];
         out_item.reg_m       = w[3:0];
      end else if ((w & SWI_MASK) == SWI_MASK) begin
         out_item.instr_class = CLASS_SWI;
         out_item.value       = {8'd0, w[23:0]};
      end else begin
         unique case (top3) inside
            TOP_DP_REG, TOP_DP_IMM: begin
               out_item.instr_class = CLASS_DP;
               out_item.alu_op      = w[24:21];
               // Compare ops carry the flag in the destination field
               if (w[24:23] == 2'b10) begin
                  out_item.suffix_flag = (w[15:12] == 4'hf);
               end else begin
                  out_item.suffix_flag = w[20];
               end
               out_item.reg_d = w[15:12];
               out_item.reg_n = w[19:16];
               if (top3 == TOP_DP_IMM) begin
                  out_item.operand_form = FORM_IMM;
                  out_item.value        = imm_rot[31:0];
               end else begin
                  out_item = reg_operand(w, out_item);
               end
            end
            TOP_XFER_IMM, TOP_XFER_REG: begin
               out_item.instr_class = CLASS_XFER;
               out_item.variant     = {w[22], w[20]};
               out_item.reg_d       = w[15:12];
               out_item.reg_n       = w[19:16];
               if (top3 == TOP_XFER_REG) begin
                  out_item = reg_operand(w, out_item);
               end else begin
                  out_item.operand_form = FORM_IMM;
               end
            end
            TOP_BLOCK: begin
               out_item.instr_class = CLASS_BLOCK;
            end
            default: begin
               out_item.instr_class = CLASS_UNKNOWN;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== sv/aifd_out_reg.sv =====
// Result register stage of the ARM instruction field decoder.
// Depends on aifd_pkg for the result payload type.
`default_nettype none

module aifd_out_reg
   import aifd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    stage_valid,
   output logic         stage_ready,
   input  wire rsp_type stage_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // Refill in the same cycle the held beat is taken.
   assign stage_ready = !valid_ff || rsp_ready;
   assign valid_in    = stage_ready ? stage_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready && stage_valid) begin
         data_ff <= stage_payload;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

`default_nettype wire

// ===== sv/arm_instruction_field_decoder.sv =====
// ARM instruction field decoder: classifies one ARM word and extracts its fields.
//
// Channels: req_ carries one beat per instruction (fetch address and word);
// rsp_ returns one beat per request with class, condition, operation bits,
// register numbers, operand form and one value (branch target, swi number,
// rotated immediate or shift amount). Both use valid/ready; a beat moves
// on a rising edge with valid and ready high.
// Path: from request acceptance to rsp_valid a beat passes through the input
// register and then the result register; decode sits between.
// Throughput: one beat per cycle, set by the single decode pass between the
// two registers; req_ready stays high while rsp_ready is high.
// Stall: when rsp_ready is low the result register holds, the input
// register still takes one more beat, and req_ready then drops until the
// receiver resumes. No beat is lost or repeated.
// Reset: synchronous, active high; both stages empty, req_ready high in the
// first cycle after reset. No configuration; state is only the stage registers.
`default_nettype none

`include "arm_instruction_field_decoder_macros.svh"

module arm_instruction_field_decoder
   import aifd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   logic    in_valid, in_ready;
   req_type in_item;
   rsp_type dec_item;

   aifd_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .stage_valid   (in_valid),
      .stage_ready   (in_ready),
      .stage_payload (in_item)
   );

   aifd_decode u_decode (
      .in_item  (in_item),
      .out_item (dec_item)
   );

   aifd_out_reg u_out_reg (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (in_valid),
      .stage_ready   (in_ready),
      .stage_payload (dec_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

   `AIFD_ASSERT_NEXT(a_req_lands, clock, reset, req_valid && req_ready, in_valid)
   `AIFD_ASSERT_NEXT(a_stage_moves, clock, reset, in_valid && in_ready, rsp_valid)
   `AIFD_ASSERT_IMPLIES(a_ready_low_full, clock, reset, !req_ready, in_valid && rsp_valid)
   `AIFD_ASSERT_IMPLIES(a_bare_class, clock, reset, rsp_valid && (rsp_payload.instr_class == CLASS_BLOCK || rsp_payload.instr_class == CLASS_UNKNOWN), rsp_payload.value == 32'd0 && rsp_payload.reg_d == 4'd0 && rsp_payload.operand_form == FORM_REG)
   `AIFD_ASSERT_IMPLIES(a_alu_op_dp, clock, reset, rsp_valid && rsp_payload.instr_class != CLASS_DP, rsp_payload.alu_op == 4'd0)

endmodule

`default_nettype wire
